// ===== rtl/core/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// shared types, register map and stage lookup for the pump stage sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned ApbW    = 32;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 48;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_PROFILE_AUTO   = 3'd0;
  localparam logic [2:0] REG_MAX_SHOT_TIME  = 3'd1;
  localparam logic [2:0] REG_TARGET_VOLUME  = 3'd2;
  localparam logic [2:0] REG_PREINFUSE_TIME = 3'd3;
  localparam logic [2:0] REG_PREINFUSE_DUTY = 3'd4;
  localparam logic [2:0] REG_HOLD_TIME      = 3'd5;
  localparam logic [2:0] REG_EXTRACT_DUTY   = 3'd6;

  localparam logic [7:0] ExtractDutyReset = 8'd255;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STG_PREINF  = 2'd0,
    STG_HOLD    = 2'd1,
    STG_EXTRACT = 2'd2,
    STG_NONE    = 2'd3
  } stage_kind_e;

  typedef struct packed {
    logic        profile_auto;
    logic [17:0] max_shot_time;
    logic [15:0] target_volume;
    logic [15:0] preinfuse_time;
    logic [7:0]  preinfuse_duty;
    logic [15:0] hold_time;
    logic [7:0]  extract_duty;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    profile_auto:   1'b0,
    max_shot_time:  18'd0,
    target_volume:  16'd0,
    preinfuse_time: 16'd0,
    preinfuse_duty: 8'd0,
    hold_time:      16'd0,
    extract_duty:   ExtractDutyReset
  };

  typedef struct packed {
    logic        running;
    logic [1:0]  stage_now;
    logic [31:0] shot_t0;
    logic [31:0] stage_t0;
  } seq_state_t;

  typedef struct packed {
    logic        done_res;
    logic [31:0] run_ms;
    logic        pump_mode;
    logic [1:0]  stage_index;
    logic [7:0]  duty_cmd;
    logic        pump_on;
  } result_t;

  // which stage of the built profile sits at a given index
  function automatic stage_kind_e stage_kind(input logic [1:0] idx,
                                             input logic has_pi,
                                             input logic has_hold);
    stage_kind_e k;
    k = STG_NONE;
    case (idx)
      2'd0: k = has_pi ? STG_PREINF : (has_hold ? STG_HOLD : STG_EXTRACT);
      2'd1: begin
        if (has_pi) begin
          k = has_hold ? STG_HOLD : STG_EXTRACT;
        end else begin
          k = has_hold ? STG_EXTRACT : STG_NONE;
        end
      end
      2'd2: k = (has_pi && has_hold) ? STG_EXTRACT : STG_NONE;
      default: k = STG_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pss_apb_regs.sv =====
// ----------------------------------------------------------------------------
// pss_apb_regs
// apb configuration register file for the pump stage sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module pss_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pss_pkg::AddrW-1:0]   paddr,
  input  wire logic [pss_pkg::ApbW-1:0]    pwdata,
  output logic      [pss_pkg::ApbW-1:0]    prdata,
  output logic                             pready,
  output pss_pkg::cfg_t                    cfg_o
);
  import pss_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PROFILE_AUTO:   cfg_d.profile_auto   = pwdata[0];
        REG_MAX_SHOT_TIME:  cfg_d.max_shot_time  = pwdata[17:0];
        REG_TARGET_VOLUME:  cfg_d.target_volume  = pwdata[15:0];
        REG_PREINFUSE_TIME: cfg_d.preinfuse_time = pwdata[15:0];
        REG_PREINFUSE_DUTY: cfg_d.preinfuse_duty = pwdata[7:0];
        REG_HOLD_TIME:      cfg_d.hold_time      = pwdata[15:0];
        REG_EXTRACT_DUTY:   cfg_d.extract_duty   = pwdata[7:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROFILE_AUTO:   prdata = {31'd0, cfg_q.profile_auto};
      REG_MAX_SHOT_TIME:  prdata = {14'd0, cfg_q.max_shot_time};
      REG_TARGET_VOLUME:  prdata = {16'd0, cfg_q.target_volume};
      REG_PREINFUSE_TIME: prdata = {16'd0, cfg_q.preinfuse_time};
      REG_PREINFUSE_DUTY: prdata = {24'd0, cfg_q.preinfuse_duty};
      REG_HOLD_TIME:      prdata = {16'd0, cfg_q.hold_time};
      REG_EXTRACT_DUTY:   prdata = {24'd0, cfg_q.extract_duty};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/pss_step.sv =====
// ----------------------------------------------------------------------------
// pss_step
// per-word sequencing logic: caps, stage advance and pump command
// ----------------------------------------------------------------------------
`default_nettype none

module pss_step (
  input  wire pss_pkg::cfg_t        cfg_i,
  input  wire pss_pkg::seq_state_t  state_i,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [31:0]          now_i,
  input  wire logic [15:0]          vol_i,
  output pss_pkg::seq_state_t       state_o,
  output logic                      res_valid_o,
  output pss_pkg::result_t          res_o
);
  import pss_pkg::*;

  logic        has_pi, has_hold;
  logic [31:0] elapsed, stage_el, stage_len;
  logic        time_trip, vol_trip, timed, adv;
  logic [1:0]  stage_nx;
  stage_kind_e kind_cur, kind_nx;
  result_t     stopped;

  assign has_pi   = cfg_i.profile_auto && (cfg_i.preinfuse_time != 16'd0);
  assign has_hold = cfg_i.profile_auto && (cfg_i.hold_time != 16'd0);

  assign elapsed   = now_i - state_i.shot_t0;
  assign stage_el  = now_i - state_i.stage_t0;
  assign time_trip = (cfg_i.max_shot_time != 18'd0) &&
                     (elapsed >= {14'd0, cfg_i.max_shot_time});
  assign vol_trip  = (cfg_i.target_volume != 16'd0) && (vol_i >= cfg_i.target_volume);

  assign kind_cur  = stage_kind(state_i.stage_now, has_pi, has_hold);
  assign timed     = (kind_cur == STG_PREINF) || (kind_cur == STG_HOLD);
  assign stage_len = (kind_cur == STG_PREINF) ? {16'd0, cfg_i.preinfuse_time}
                                              : {16'd0, cfg_i.hold_time};
  // a timed stage is never zero long, so one advance per tick at most
  assign adv       = timed && (stage_el >= stage_len);
  assign stage_nx  = adv ? state_i.stage_now + 2'd1 : state_i.stage_now;
  assign kind_nx   = adv ? stage_kind(stage_nx, has_pi, has_hold) : kind_cur;

  always_comb begin
    stopped              = '0;
    stopped.stage_index  = state_i.stage_now;
    stopped.done_res     = 1'b1;

    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = stopped;

    unique case (cmd_e'(cmd_i))
      CMD_START: begin
        state_o.running   = 1'b1;
        state_o.stage_now = 2'd0;
        state_o.shot_t0   = now_i;
        state_o.stage_t0  = now_i;
      end
      CMD_STOP: begin
        state_o.running = 1'b0;
      end
      CMD_TICK: begin
        res_valid_o = 1'b1;
        if (state_i.running) begin
          if (time_trip || vol_trip) begin
            state_o.running = 1'b0;
          end else begin
            if (adv) begin
              state_o.stage_now = stage_nx;
              state_o.stage_t0  = now_i;
            end
            if (kind_nx == STG_NONE) begin
              state_o.running   = 1'b0;
              res_o.stage_index = stage_nx;
            end else begin
              res_o.done_res     = 1'b0;
              res_o.stage_index  = stage_nx;
              res_o.run_ms       = elapsed;
              res_o.pump_mode    = (kind_nx != STG_HOLD);
              case (kind_nx)
                STG_PREINF:  res_o.duty_cmd = cfg_i.preinfuse_duty;
                STG_EXTRACT: res_o.duty_cmd = cfg_i.extract_duty;
                default:     res_o.duty_cmd = 8'd0;
              endcase
              res_o.pump_on = (res_o.duty_cmd != 8'd0);
            end
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/pump_stage_sequencer.sv =====
// ----------------------------------------------------------------------------
// pump_stage_sequencer
// steps a pump through pre-infusion, hold and extraction stages of a shot
// ----------------------------------------------------------------------------
// usage
//   s_axis carries command words: tuser holds the command (tick, start,
//   stop), tdata the millisecond clock and the measured volume
//   m_axis returns one status word for every tick; start and stop words
//   update the shot state and return nothing
//   the apb port holds the profile registers; write them while no word is
//   in flight
// timing
//   a word sits one cycle in the input register and its status word is
//   registered at the next edge: two cycles from acceptance to the
//   earliest m_axis transfer
//   one word per cycle sustained, set by the single input and result
//   register pair around the compare logic
// reset
//   rst_ni clears the shot state, the valid flags of both word registers
//   and the profile registers, extract duty comes up at full
// stalls
//   with m_axis_tready low the status word holds and one more word waits
//   in the input register; s_axis_tready drops only when both are full
// ----------------------------------------------------------------------------
`default_nettype none

module pump_stage_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command word
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] now_ms, [47:32] volume
  input  wire logic [pss_pkg::InDataW-1:0]     s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]                      s_axis_tuser,
  // status word
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] pump_on, [8:1] duty_cmd, [10:9] stage_index, [11] pump_mode,
  // [43:12] run_ms, [44] done_res, [47:45] zero
  output logic      [pss_pkg::OutDataW-1:0]    m_axis_tdata,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pss_pkg::AddrW-1:0]       paddr,
  input  wire logic [pss_pkg::ApbW-1:0]        pwdata,
  output logic      [pss_pkg::ApbW-1:0]        prdata,
  output logic                                 pready
);
  import pss_pkg::*;

  cfg_t        cfg;
  seq_state_t  state_q, state_d;
  result_t     res, out_q;
  logic        res_valid;

  logic        in_valid_q, in_valid_d;
  logic [1:0]  in_cmd_q;
  logic [31:0] in_now_q;
  logic [15:0] in_vol_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free, fire, in_take;

  pss_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pss_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .cmd_i       (in_cmd_q),
    .now_i       (in_now_q),
    .vol_i       (in_vol_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= s_axis_tuser;
      in_now_q <= s_axis_tdata[31:0];
      in_vol_q <= s_axis_tdata[47:32];
    end
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q};

`ifndef SYNTHESIS
  a_done_pump_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |->
      !out_q.pump_on && (out_q.duty_cmd == 8'd0) && (out_q.run_ms == 32'd0))
    else $error("finished shot reports a running pump");

  a_live_stage_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.done_res |-> (out_q.stage_index != 2'd3))
    else $error("running shot reports an impossible stage");

  a_stop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q.running) |-> $past(fire))
    else $error("shot stopped without a command word");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the pump stage sequencer against its own shot model. directed shots
// cover clock wrap, both caps, stage skips and a profile cut short between
// words, then random shots run under several register settings with random
// gaps and stalls on both streams. every status word is compared field by
// field with the oldest predicted one
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import pss_pkg::*;

  localparam logic [1:0]  CMD_SPARE         = 2'd3;
  localparam logic        MODE_OFF          = 1'b0;
  localparam logic        MODE_FIXED        = 1'b1;
  localparam int unsigned DRAIN_CYCLES      = 4;
  localparam int unsigned HOLD_OFF_CYCLES   = 64;
  localparam int unsigned WORDS_PER_SETTING = 125;
  localparam int unsigned NUM_SETTINGS      = 8;

  class shot_scoreboard;
    cfg_t        cfg;
    logic        running;
    int unsigned stage_now;
    logic [31:0] shot_t0;
    logic [31:0] stage_t0;
    result_t     status_q[$];
    int unsigned fails;
    int unsigned checked;

    function new();
      cfg              = '0;
      cfg.extract_duty = ExtractDutyReset;
      running          = 1'b0;
      stage_now        = 0;
      shot_t0          = '0;
      stage_t0         = '0;
      fails            = 0;
      checked          = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_PROFILE_AUTO:   cfg.profile_auto   = val[0];
        REG_MAX_SHOT_TIME:  cfg.max_shot_time  = val[17:0];
        REG_TARGET_VOLUME:  cfg.target_volume  = val[15:0];
        REG_PREINFUSE_TIME: cfg.preinfuse_time = val[15:0];
        REG_PREINFUSE_DUTY: cfg.preinfuse_duty = val[7:0];
        REG_HOLD_TIME:      cfg.hold_time      = val[15:0];
        REG_EXTRACT_DUTY:   cfg.extract_duty   = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    function void push_stopped();
      result_t r;
      r             = '0;
      r.pump_mode   = MODE_OFF;
      r.stage_index = 2'(stage_now);
      r.done_res    = 1'b1;
      running       = 1'b0;
      status_q.push_back(r);
    endfunction

    function void note_word(logic [1:0] cmd, logic [31:0] now, logic [15:0] vol);
      logic [7:0]  duty [3];
      logic        mode [3];
      logic        timed [3];
      logic [31:0] len [3];
      int unsigned n;
      logic [31:0] elapsed;
      result_t     r;
      if (cmd == CMD_START) begin
        stage_now = 0;
        shot_t0   = now;
        stage_t0  = now;
        running   = 1'b1;
        return;
      end
      if (cmd == CMD_STOP) begin
        running = 1'b0;
        return;
      end
      if (cmd != CMD_TICK) return;
      if (!running) begin
        push_stopped();
        return;
      end
      elapsed = now - shot_t0;
      if ((cfg.max_shot_time != '0 && elapsed >= cfg.max_shot_time) ||
          (cfg.target_volume != '0 && vol >= cfg.target_volume)) begin
        push_stopped();
        return;
      end
      // stage list follows the registers as they stand now
      n = 0;
      if (cfg.profile_auto) begin
        if (cfg.preinfuse_time != '0) begin
          duty[n] = cfg.preinfuse_duty;
          mode[n] = MODE_FIXED;
          timed[n] = 1'b1;
          len[n] = 32'(cfg.preinfuse_time);
          n++;
        end
        if (cfg.hold_time != '0) begin
          duty[n] = '0;
          mode[n] = MODE_OFF;
          timed[n] = 1'b1;
          len[n] = 32'(cfg.hold_time);
          n++;
        end
      end
      duty[n] = cfg.extract_duty;
      mode[n] = MODE_FIXED;
      timed[n] = 1'b0;
      len[n] = '0;
      n++;
      while (stage_now < n && timed[stage_now] && (now - stage_t0) >= len[stage_now]) begin
        stage_now++;
        stage_t0 = now;
      end
      if (stage_now >= n) begin
        push_stopped();
        return;
      end
      r              = '0;
      r.pump_on      = (duty[stage_now] != '0);
      r.duty_cmd     = duty[stage_now];
      r.stage_index  = 2'(stage_now);
      r.pump_mode    = mode[stage_now];
      r.run_ms       = elapsed;
      r.done_res     = 1'b0;
      status_q.push_back(r);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %0h, expected %0h (status word %0d)",
               field, got, want, checked);
      fails++;
    endtask

    task check_status(logic [OutDataW-1:0] word);
      result_t got;
      result_t want;
      got = word[$bits(result_t)-1:0];
      if (status_q.size() == 0) begin
        report_mismatch("status word with none pending", word[31:0], '0);
        return;
      end
      want = status_q.pop_front();
      checked++;
      if (got.pump_on != want.pump_on)
        report_mismatch("pump_on", 32'(got.pump_on), 32'(want.pump_on));
      if (got.duty_cmd != want.duty_cmd)
        report_mismatch("duty_cmd", 32'(got.duty_cmd), 32'(want.duty_cmd));
      if (got.stage_index != want.stage_index)
        report_mismatch("stage_index", 32'(got.stage_index), 32'(want.stage_index));
      if (got.pump_mode != want.pump_mode)
        report_mismatch("pump_mode", 32'(got.pump_mode), 32'(want.pump_mode));
      if (got.run_ms != want.run_ms)
        report_mismatch("run_ms", got.run_ms, want.run_ms);
      if (got.done_res != want.done_res)
        report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
      if (word[OutDataW-1:$bits(result_t)] != '0)
        report_mismatch("pad bits", 32'(word[OutDataW-1:$bits(result_t)]), '0);
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [ApbW-1:0]     pwdata        = '0;
  logic [ApbW-1:0]     prdata;
  logic                pready;

  shot_scoreboard sb = new();

  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_reqs     = 0;
  int unsigned words_sent    = 0;
  int unsigned ignored_words = 0;
  int unsigned shots         = 0;

  pump_stage_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
  end

  initial begin : receiver
    int unsigned hold_served;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
        hold_served++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] now,
                           input logic [15:0] vol);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vol, now};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, now, vol);
    if (cmd == CMD_SPARE) ignored_words++;
    else words_sent++;
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_profile(input cfg_t c);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_PROFILE_AUTO, 32'(c.profile_auto));
    write_reg(REG_MAX_SHOT_TIME, 32'(c.max_shot_time));
    write_reg(REG_TARGET_VOLUME, 32'(c.target_volume));
    write_reg(REG_PREINFUSE_TIME, 32'(c.preinfuse_time));
    write_reg(REG_PREINFUSE_DUTY, 32'(c.preinfuse_duty));
    write_reg(REG_HOLD_TIME, 32'(c.hold_time));
    write_reg(REG_EXTRACT_DUTY, 32'(c.extract_duty));
  endtask

  function automatic logic [15:0] random_stage_len();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3) return '0;
    if (pick == 3) return 16'($urandom());
    return 16'($urandom_range(1, 200));
  endfunction

  function automatic cfg_t random_profile(input int unsigned k);
    cfg_t c;
    if (k == 0) begin
      c = '0;
    end else if (k == 1) begin
      c = '1;
    end else begin
      c.profile_auto   = 1'($urandom_range(1));
      c.max_shot_time  = ($urandom_range(9) < 3) ? '0 :
                         ($urandom_range(9) == 0) ? 18'($urandom()) :
                         18'($urandom_range(60, 3000));
      c.target_volume  = ($urandom_range(9) < 3) ? '0 :
                         ($urandom_range(9) == 0) ? 16'($urandom()) :
                         16'($urandom_range(50, 1500));
      c.preinfuse_time = random_stage_len();
      c.preinfuse_duty = 8'($urandom());
      c.hold_time      = random_stage_len();
      c.extract_duty   = 8'($urandom());
    end
    return c;
  endfunction

  task automatic run_shot();
    logic [31:0] now;
    logic [15:0] vol;
    int unsigned ticks;
    now   = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(500) : $urandom();
    vol   = '0;
    ticks = $urandom_range(3, 30);
    shots++;
    send_word(CMD_START, now, 16'($urandom()));
    sender_gap();
    repeat (ticks) begin
      now = now + $urandom_range(80);
      vol = vol + 16'($urandom_range(40));
      // occasional stray word of any code, clock and volume
      if ($urandom_range(99) < 6) send_word(2'($urandom_range(3)), $urandom(), 16'($urandom()));
      else send_word(CMD_TICK, now, vol);
      sender_gap();
    end
    if ($urandom_range(1) == 1) begin
      send_word(CMD_STOP, now, vol);
      sender_gap();
    end
  endtask

  initial begin : stimulus
    cfg_t        c;
    int unsigned goal;
    bit          paused;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset profile: extraction only at full duty, no caps
    send_word(CMD_TICK, 32'h0000_0000, 16'h0000);
    send_word(CMD_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(CMD_START, 32'hFFFF_FFF0, 16'h0000);
    send_word(CMD_TICK, 32'h0000_0010, 16'hFFFF);
    send_word(CMD_STOP, 32'h0000_0020, 16'h0000);
    send_word(CMD_TICK, 32'h0000_0030, 16'h0000);

    // timed stages, zero pre-infusion duty, volume cap then time cap
    c                = '0;
    c.profile_auto   = 1'b1;
    c.max_shot_time  = 18'd1000;
    c.target_volume  = 16'd500;
    c.preinfuse_time = 16'd100;
    c.hold_time      = 16'd50;
    c.extract_duty   = 8'h80;
    write_profile(c);
    send_word(CMD_START, 32'd1000, 16'd0);
    send_word(CMD_TICK, 32'd1000, 16'd0);
    send_word(CMD_TICK, 32'd1099, 16'd10);
    send_word(CMD_TICK, 32'd1100, 16'd20);
    send_word(CMD_TICK, 32'd1150, 16'd30);
    send_word(CMD_TICK, 32'd1999, 16'd499);
    send_word(CMD_TICK, 32'd1999, 16'd500);
    send_word(CMD_TICK, 32'd2000, 16'd0);
    send_word(CMD_START, 32'd5000, 16'd0);
    send_word(CMD_TICK, 32'd5400, 16'd0);
    send_word(CMD_TICK, 32'd6000, 16'd0);

    // every register at its top value, stages ending across the clock wrap
    write_profile('1);
    send_word(CMD_START, 32'hFFFF_0000, 16'd0);
    send_word(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFE);
    send_word(CMD_TICK, 32'h0000_FFFE, 16'd0);
    send_word(CMD_TICK, 32'h0004_0000, 16'd0);
    send_word(CMD_START, 32'd0, 16'd0);
    send_word(CMD_TICK, 32'd200, 16'd0);

    // profile rewritten while a shot runs, then cut below the current stage
    c                = '0;
    c.profile_auto   = 1'b1;
    c.preinfuse_time = 16'd10;
    c.hold_time      = 16'd10;
    c.extract_duty   = 8'h40;
    write_profile(c);
    send_word(CMD_TICK, 32'd300, 16'd0);
    write_profile('0);
    send_word(CMD_TICK, 32'd310, 16'd0);
    send_word(CMD_START, 32'd400, 16'd0);
    send_word(CMD_TICK, 32'd400, 16'd0);

    for (int unsigned k = 0; k < NUM_SETTINGS; k++) begin
      write_profile(random_profile(k));
      case (k % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 17; stall_pct = 17; end
      endcase
      if (k % 4 == 0) hold_reqs <= hold_reqs + 1;
      goal   = words_sent + WORDS_PER_SETTING;
      paused = 1'b0;
      while (words_sent < goal) begin
        run_shot();
        if (!paused && words_sent >= goal - WORDS_PER_SETTING / 2) begin
          wait_results();
          paused = 1'b1;
        end
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d command words plus %0d spare-code words in %0d random shots",
             words_sent, ignored_words, shots);
    $display("over %0d register settings; %0d status words checked, %0d mismatches",
             NUM_SETTINGS + 5, sb.checked, sb.fails);
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
